// ----- rtl/c2d_pkg.sv -----
// Shared constants, types and helpers for the 2D convolution block.
`timescale 1ns / 1ps

package c2d_pkg;

    // Sizing limits
    localparam int MAX_KERNEL = 5;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int KSTORE     = MAX_KERNEL * MAX_KERNEL;

    // Fixed field widths
    localparam int DATA_W     = 32;
    localparam int CIDX_W     = 5;
    localparam int KS_W       = 3;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Derived widths
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int KE_W    = $clog2(MAX_KERNEL + 1);
    localparam int KIDX_W  = (KSTORE > 1) ? $clog2(KSTORE) : 1;
    localparam int LB_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int LB_W    = LB_ROWS * DATA_W;

    // Register reset values
    localparam int KSIZE_RST  = 3;
    localparam int WIDTH_RST  = 1024;
    localparam int HEIGHT_RST = 1024;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [CIDX_W-1:0] t_cidx;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [KE_W-1:0]   t_ksize;
    typedef logic [KIDX_W-1:0] t_kidx;
    typedef logic [LB_W-1:0]   t_lbword;

    typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][DATA_W-1:0] t_win;
    typedef logic [KSTORE-1:0][DATA_W-1:0]                     t_kern;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_COEF  = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SIZE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    // Line buffer port: read at accept, write when the word leaves the input stage
    typedef struct packed {
        logic    rd_en;
        t_col    rd_addr;
        logic    wr_en;
        t_col    wr_addr;
        t_lbword wr_data;
    } t_lb_ctl;

    // Advance strobes of the multiply / add stages
    typedef struct packed {
        logic prod_en;
        logic row_en;
        logic sum_en;
    } t_mac_en;

    // Kernel entry for window tap (d rows up, h columns back) at kernel side k
    function automatic t_kidx kern_pos(input t_ksize k, input int unsigned d,
                                       input int unsigned h);
        int unsigned ki;
        int unsigned i;
        int unsigned j;
        ki = int'(k);
        i  = ki - 1 - d;
        j  = ki - 1 - h;
        return t_kidx'(i * ki + j);
    endfunction

endpackage

// ----- rtl/c2d_in_if.sv -----
// Input stream interface: pixel or coefficient words.
`timescale 1ns / 1ps

interface c2d_in_if;
    import c2d_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    t_cidx coef_index;
    t_data data_value;

    modport source (output valid, kind, coef_index, data_value, input ready);
    modport sink   (input valid, kind, coef_index, data_value, output ready);
endinterface

// ----- rtl/c2d_out_if.sv -----
// Output stream interface: convolution result words.
`timescale 1ns / 1ps

interface c2d_out_if;
    import c2d_pkg::*;

    logic  valid;
    logic  ready;
    t_data conv_sum;
    t_row  out_row;
    t_col  out_col;
    logic  last_of_image;

    modport source (output valid, conv_sum, out_row, out_col, last_of_image, input ready);
    modport sink   (input valid, conv_sum, out_row, out_col, last_of_image, output ready);
endinterface

// ----- rtl/c2d_linebuf.sv -----
// Line buffer: one entry per column holding the previous rows, with write-to-read bypass.
`timescale 1ns / 1ps

module c2d_linebuf (
    input  logic             i_clk,
    input  c2d_pkg::t_lb_ctl i_ctl,
    output c2d_pkg::t_lbword o_rd_data
);
    import c2d_pkg::*;

    t_lbword r_mem [MAX_WIDTH];
    t_lbword r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // one-column images read the entry being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            if (i_ctl.wr_en && (i_ctl.wr_addr == i_ctl.rd_addr)) begin
                r_rd_data <= i_ctl.wr_data;
            end else begin
                r_rd_data <= r_mem[i_ctl.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/c2d_mac.sv -----
// Window multiply and three-stage sum: products, row sums, total.
`timescale 1ns / 1ps

module c2d_mac (
    input  logic             i_clk,
    input  c2d_pkg::t_mac_en i_en,
    input  c2d_pkg::t_win    i_win,
    input  c2d_pkg::t_kern   i_kern,
    input  c2d_pkg::t_ksize  i_ksize,
    output c2d_pkg::t_data   o_sum
);
    import c2d_pkg::*;

    t_data r_prod    [MAX_KERNEL][MAX_KERNEL];
    t_data n_prod    [MAX_KERNEL][MAX_KERNEL];
    t_data r_row_sum [MAX_KERNEL];
    t_data n_row_sum [MAX_KERNEL];
    t_data r_sum;
    t_data n_sum;
    t_kidx kp        [MAX_KERNEL][MAX_KERNEL];

    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            for (int h = 0; h < MAX_KERNEL; h++) begin
                kp[d][h] = kern_pos(i_ksize, d, h);
            end
        end
    end

    // taps outside the active kernel contribute zero
    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            for (int h = 0; h < MAX_KERNEL; h++) begin
                if ((d < int'(i_ksize)) && (h < int'(i_ksize))) begin
                    n_prod[d][h] = t_data'(i_win[d][h] * i_kern[kp[d][h]]);
                end else begin
                    n_prod[d][h] = '0;
                end
            end
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            n_row_sum[d] = '0;
            for (int h = 0; h < MAX_KERNEL; h++) begin
                n_row_sum[d] = n_row_sum[d] + r_prod[d][h];
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int d = 0; d < MAX_KERNEL; d++) begin
            n_sum = n_sum + r_row_sum[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod_en) begin
            r_prod <= n_prod;
        end
        if (i_en.row_en) begin
            r_row_sum <= n_row_sum;
        end
        if (i_en.sum_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- rtl/conv2d_valid_stride1.sv -----
// Top level: streaming 2D valid-mode convolution, stride 1, unflipped kernel.
//
//  channel   dir  handshake          payload
//  i_pix     in   valid/ready        kind, coef_index, data_value
//  o_res     out  valid/ready        conv_sum, out_row, out_col, last_of_image
//  i_cfg_*   in   i_cfg_we only      i_cfg_index, i_cfg_data
//
// Throughput: one word per cycle while o_res is not holding the pipe back. A result passes
// through the input stage, window stage, products, row sums and total before it is valid.
// Reset: synchronous, active low; clears pipeline valids, position counters and the
// registers (kernel side 3, 1024 x 1024). Kernel and line buffer contents are not cleared.
// Stalls: each stage advances when the one after it is empty or moving, so empty slots
// keep absorbing words while a finished result waits on o_res.
`timescale 1ns / 1ps

module conv2d_valid_stride1 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    c2d_in_if.sink                            i_pix,
    c2d_out_if.source                         o_res
);
    import c2d_pkg::*;

    typedef struct packed {
        t_row orow;
        t_col ocol;
        logic last;
    } t_meta;

    typedef struct packed {
        t_kind kind;
        t_cidx idx;
        t_data val;
        t_col  col;
        logic  emit;
        t_meta meta;
    } t_item;

    // ---------------- configuration ----------------
    logic [KS_W-1:0] r_ksize;
    logic [IW_W-1:0] r_width;
    logic [IH_W-1:0] r_height;
    logic            cfg_hit;

    t_ksize          k_eff;
    t_ksize          k_m1;
    logic [COL_W:0]  w_eff;
    logic [ROW_W:0]  h_eff;

    assign cfg_hit = i_cfg_we && ((i_cfg_index == CFG_KERNEL_SIZE)
                               || (i_cfg_index == CFG_IMAGE_WIDTH)
                               || (i_cfg_index == CFG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize  <= KS_W'(KSIZE_RST);
            r_width  <= IW_W'(WIDTH_RST);
            r_height <= IH_W'(HEIGHT_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KERNEL_SIZE:  r_ksize  <= i_cfg_data[KS_W-1:0];
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[IW_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[IH_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    always_comb begin
        if (r_ksize == '0) begin
            k_eff = t_ksize'(1);
        end else if (int'(r_ksize) > MAX_KERNEL) begin
            k_eff = t_ksize'(MAX_KERNEL);
        end else begin
            k_eff = t_ksize'(r_ksize);
        end

        if (r_width == '0) begin
            w_eff = (COL_W+1)'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W+1)'(r_width);
        end

        if (r_height == '0) begin
            h_eff = (ROW_W+1)'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (ROW_W+1)'(r_height);
        end
    end

    assign k_m1 = k_eff - t_ksize'(1);

    // ---------------- stage enables ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;
    logic acc, acc_pix;

    assign en5 = !r_v5 || o_res.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_pix.ready = en1;
    assign acc         = i_pix.valid && en1;
    assign acc_pix     = acc && (i_pix.kind == KIND_PIXEL);

    // ---------------- raster position ----------------
    t_row r_row_cnt, n_row_cnt;
    t_col r_col_cnt, n_col_cnt;
    logic col_last, row_last, img_last;
    logic win_full;

    assign col_last = ({1'b0, r_col_cnt} == (w_eff - 1'b1));
    assign row_last = ({1'b0, r_row_cnt} == (h_eff - 1'b1));
    assign img_last = col_last && row_last;
    assign win_full = (r_row_cnt >= ROW_W'(k_m1)) && (r_col_cnt >= COL_W'(k_m1));

    always_comb begin
        n_row_cnt = r_row_cnt;
        n_col_cnt = r_col_cnt;
        if (cfg_hit) begin
            n_row_cnt = '0;
            n_col_cnt = '0;
        end else if (acc_pix) begin
            if (col_last) begin
                n_col_cnt = '0;
                n_row_cnt = row_last ? '0 : r_row_cnt + 1'b1;
            end else begin
                n_col_cnt = r_col_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else begin
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
        end
    end

    // ---------------- input stage ----------------
    t_item r_s1, r_s2, n_item;

    always_comb begin
        n_item.kind      = t_kind'(i_pix.kind);
        n_item.idx       = i_pix.coef_index;
        n_item.val       = i_pix.data_value;
        n_item.col       = r_col_cnt;
        n_item.emit      = win_full;
        n_item.meta.orow = r_row_cnt - ROW_W'(k_m1);
        n_item.meta.ocol = r_col_cnt - COL_W'(k_m1);
        n_item.meta.last = img_last;
    end

    // ---------------- line buffer ----------------
    t_lb_ctl lb_ctl;
    t_lbword lb_rd;
    logic    s1_move_pix;

    assign s1_move_pix = r_v1 && en2 && (r_s1.kind == KIND_PIXEL);

    always_comb begin
        lb_ctl.rd_en   = acc_pix;
        lb_ctl.rd_addr = r_col_cnt;
        lb_ctl.wr_en   = s1_move_pix;
        lb_ctl.wr_addr = r_s1.col;
        // push the new pixel in, oldest row drops off the top
        lb_ctl.wr_data = t_lbword'({lb_rd, r_s1.val});
    end

    c2d_linebuf u_linebuf (
        .i_clk     (i_clk),
        .i_ctl     (lb_ctl),
        .o_rd_data (lb_rd)
    );

    // ---------------- window (belongs to stage 2) ----------------
    // r_win[d][h]: d rows above, h columns left of the newest pixel
    t_win r_win, n_win;

    always_comb begin
        n_win = r_win;
        if (s1_move_pix) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                for (int h = MAX_KERNEL - 1; h > 0; h--) begin
                    n_win[d][h] = r_win[d][h-1];
                end
                if (d == 0) begin
                    n_win[d][0] = r_s1.val;
                end else begin
                    n_win[d][0] = lb_rd[(d-1)*DATA_W +: DATA_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    // ---------------- kernel store ----------------
    // coefficient loads take effect in stream order, as they leave stage 2
    t_kern r_kern;
    logic  kern_we;

    assign kern_we = r_v2 && en3 && (r_s2.kind == KIND_COEF) && (int'(r_s2.idx) < KSTORE);

    always_ff @(posedge i_clk) begin
        if (kern_we) begin
            r_kern[t_kidx'(r_s2.idx)] <= r_s2.val;
        end
    end

    // ---------------- multiply / add stages ----------------
    t_mac_en mac_en;
    t_data   mac_sum;
    logic    s2_emit;
    t_meta   r_meta3, r_meta4, r_meta5;

    assign s2_emit = (r_s2.kind == KIND_PIXEL) && r_s2.emit;

    always_comb begin
        mac_en.prod_en = en3 && r_v2 && s2_emit;
        mac_en.row_en  = en4 && r_v3;
        mac_en.sum_en  = en5 && r_v4;
    end

    c2d_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (mac_en),
        .i_win   (r_win),
        .i_kern  (r_kern),
        .i_ksize (k_eff),
        .o_sum   (mac_sum)
    );

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= acc;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2 && s2_emit;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_item;
        end
        if (en2) begin
            r_s2 <= r_s1;
        end
        if (en3) begin
            r_meta3 <= r_s2.meta;
        end
        if (en4) begin
            r_meta4 <= r_meta3;
        end
        if (en5) begin
            r_meta5 <= r_meta4;
        end
    end

    // ---------------- output ----------------
    assign o_res.valid         = r_v5;
    assign o_res.conv_sum      = mac_sum;
    assign o_res.out_row       = r_meta5.orow;
    assign o_res.out_col       = r_meta5.ocol;
    assign o_res.last_of_image = r_meta5.last;

    // ---------------- assertions ----------------
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col_cnt} < w_eff) && ({1'b0, r_row_cnt} < h_eff))
        else $error("raster position outside image");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_pix && img_last) |=> (r_row_cnt == '0) && (r_col_cnt == '0))
        else $error("position did not wrap after last pixel");

    a_coef_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3 && (r_s2.kind == KIND_COEF)) |=> !r_v3)
        else $error("coefficient word entered the multiply stage");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v5) |-> $past(r_v4))
        else $error("result word appeared without a pending sum");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the streaming 2D valid-mode convolution block.
`timescale 1ns / 1ps

import c2d_pkg::*;

// Tracks the kernel, the recent image rows and the raster position, and holds the
// window sums the block still owes.
class conv_scoreboard;
    typedef struct packed {
        t_data sum;
        t_row  row;
        t_col  col;
        logic  last;
    } t_conv_result;

    t_data           coef_mem [KSTORE];
    t_data           row_mem  [MAX_KERNEL][MAX_WIDTH];
    logic [KS_W-1:0] ksize_reg;
    logic [IW_W-1:0] width_reg;
    logic [IH_W-1:0] height_reg;
    int unsigned     row_pos;
    int unsigned     col_pos;
    t_conv_result    sums_due [$];
    int unsigned     matched;
    int unsigned     mismatches;

    function new();
        ksize_reg  = KS_W'(KSIZE_RST);
        width_reg  = IW_W'(WIDTH_RST);
        height_reg = IH_W'(HEIGHT_RST);
        row_pos    = 0;
        col_pos    = 0;
        matched    = 0;
        mismatches = 0;
    endfunction

    static function int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Any valid register write restarts the image; the unused index does nothing.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_KERNEL_SIZE:  ksize_reg  = val[KS_W-1:0];
            CFG_IMAGE_WIDTH:  width_reg  = val[IW_W-1:0];
            CFG_IMAGE_HEIGHT: height_reg = val[IH_W-1:0];
            default:          return;
        endcase
        row_pos = 0;
        col_pos = 0;
    endfunction

    function void note_word(t_kind kind, t_cidx idx, t_data val);
        int unsigned  k;
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        t_data        sum;
        t_conv_result res;
        if (kind == KIND_COEF) begin
            if (idx < KSTORE) coef_mem[idx] = val;
            return;
        end
        k = clamp_to(ksize_reg, MAX_KERNEL);
        w = clamp_to(width_reg, MAX_WIDTH);
        h = clamp_to(height_reg, MAX_HEIGHT);
        r = (row_pos >= h) ? 0 : row_pos;
        c = (col_pos >= w) ? 0 : col_pos;
        row_mem[r % MAX_KERNEL][c] = val;
        if (r + 1 >= k && c + 1 >= k) begin
            sum = '0;
            for (int unsigned i = 0; i < k; i++) begin
                for (int unsigned j = 0; j < k; j++) begin
                    // 32-bit context: product and sum both wrap
                    sum += row_mem[(r - k + 1 + i) % MAX_KERNEL][c - k + 1 + j]
                           * coef_mem[i * k + j];
                end
            end
            res.sum  = sum;
            res.row  = t_row'(r - k + 1);
            res.col  = t_col'(c - k + 1);
            res.last = (r == h - 1) && (c == w - 1);
            sums_due.push_back(res);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function void check_result(t_data sum, t_row row, t_col col, logic last);
        t_conv_result due;
        if (sums_due.size() == 0) begin
            $error("result with nothing pending: conv_sum %h out_row %0d out_col %0d",
                   sum, row, col);
            mismatches++;
            return;
        end
        due = sums_due.pop_front();
        if (sum !== due.sum) begin
            $error("conv_sum mismatch: expected %h, actual %h", due.sum, sum);
            mismatches++;
        end
        if (row !== due.row) begin
            $error("out_row mismatch: expected %0d, actual %0d", due.row, row);
            mismatches++;
        end
        if (col !== due.col) begin
            $error("out_col mismatch: expected %0d, actual %0d", due.col, col);
            mismatches++;
        end
        if (last !== due.last) begin
            $error("last_of_image mismatch: expected %b, actual %b", due.last, last);
            mismatches++;
        end
        matched++;
    endfunction

    function int unsigned pending();
        return sums_due.size();
    endfunction
endclass

module tb;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Five pipeline stages plus margin; also covers coefficient words in flight
    localparam int CLEAR_CYCLES = 8;
    localparam int RANDOM_WORDS = 780;
    // Receiver hold-off long enough to back the whole pipe up into the input
    localparam int LONG_HOLD    = 300;
    localparam int END_WAIT     = 5000;
    // Pixels sent in each of the oversize width and height checks
    localparam int SAT_PIXELS   = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    c2d_in_if  pix_if ();
    c2d_out_if res_if ();

    conv_scoreboard sb;
    int unsigned    random_words;
    int unsigned    send_run;

    conv2d_valid_stride1 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sender pacing: bursts with no gap, mostly short gaps, now and then a long one.
    function automatic int unsigned next_gap();
        int unsigned pick;
        if (send_run != 0) begin
            send_run--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_run = $urandom_range(5, 60);
            return 0;
        end
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Pixel values lean on the extremes so the wrapping arithmetic gets exercised.
    function automatic t_data pick_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return '0;
        if (pick < 10) return '1;
        return $urandom();
    endfunction

    // Inputs change on the falling edge; acceptance is seen on the rising edge.
    task automatic send_word(t_kind kind, t_cidx idx, t_data val);
        int unsigned gap;
        gap = next_gap();
        repeat (gap) begin
            @(negedge i_clk);
            pix_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        pix_if.valid      <= 1'b1;
        pix_if.kind       <= kind;
        pix_if.coef_index <= idx;
        pix_if.data_value <= val;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        sb.note_word(kind, idx, val);
    endtask

    // Coefficient index is a don't-care on pixels, so it is randomized there too.
    task automatic send_pixel(t_data val);
        send_word(KIND_PIXEL, t_cidx'($urandom()), val);
    endtask

    // Stop sending, collect every pending sum, then let the pipe empty out.
    task automatic drain();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (CLEAR_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_shape(int unsigned ks, int unsigned wd, int unsigned ht);
        cfg_write(CFG_KERNEL_SIZE, CFG_DATA_W'(ks));
        cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(wd));
        cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(ht));
    endtask

    // One random setting: mostly whole images (sometimes two, to cross the wrap),
    // sometimes a truncated one; coefficient words and full drains are mixed in.
    task automatic random_phase();
        int unsigned ks;
        int unsigned wd;
        int unsigned ht;
        int unsigned k;
        int unsigned area;
        int unsigned pixels;
        int unsigned pick;
        t_cidx       cidx;
        pick = $urandom_range(0, 99);
        if (pick < 8) ks = 0;
        else if (pick < 16) ks = $urandom_range(MAX_KERNEL + 1, 7);
        else ks = $urandom_range(1, MAX_KERNEL);
        k = sb.clamp_to(ks, MAX_KERNEL);
        pick = $urandom_range(0, 99);
        if (pick < 5) wd = 0;
        else if (pick < 10) wd = $urandom_range(MAX_WIDTH + 1, 2047);
        else wd = $urandom_range(1, k + 8);
        pick = $urandom_range(0, 99);
        if (pick < 5) ht = 0;
        else if (pick < 10) ht = $urandom_range(MAX_HEIGHT + 1, 8191);
        else ht = $urandom_range(1, k + 6);
        area = sb.clamp_to(wd, MAX_WIDTH) * sb.clamp_to(ht, MAX_HEIGHT);

        drain();
        set_shape(ks, wd, ht);
        if ($urandom_range(0, 9) == 0) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));

        if (area > 400) pixels = $urandom_range(1, 60);
        else if ($urandom_range(0, 99) < 15) pixels = $urandom_range(1, area);
        else pixels = area * $urandom_range(1, 2);

        for (int unsigned i = 0; i < pixels; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                // kernel update mid-image; indexes past the store are dropped
                cidx = t_cidx'($urandom_range(0, 31));
                send_word(KIND_COEF, cidx, $urandom());
                if (cidx < KSTORE) random_words++;
            end else if (pick == 5) begin
                drain();
            end
            send_pixel(pick_pixel());
            random_words++;
        end
    endtask

    initial begin : stimulus
        sb           = new();
        random_words = 0;
        send_run     = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        pix_if.valid      = 1'b0;
        pix_if.kind       = KIND_PIXEL;
        pix_if.coef_index = '0;
        pix_if.data_value = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every kernel entry before any window can read one.
        for (int unsigned i = 0; i < KSTORE; i++) begin
            if (i == 0) send_word(KIND_COEF, t_cidx'(i), '1);
            else if (i == 1) send_word(KIND_COEF, t_cidx'(i), '0);
            else if (i == 2) send_word(KIND_COEF, t_cidx'(i), 32'h8000_0000);
            else send_word(KIND_COEF, t_cidx'(i), $urandom());
        end

        // Loads past the store must not land anywhere.
        send_word(KIND_COEF, t_cidx'(KSTORE), '1);
        send_word(KIND_COEF, '1, '1);

        // Reset shape is 3x3 on 1024-wide rows: a few pixels complete no window.
        repeat (3) send_pixel(pick_pixel());

        // 2x2 kernel over a 3x2 image: two sums, the second ends the image.
        drain();
        set_shape(2, 3, 2);
        send_pixel('1);
        send_pixel('1);
        send_pixel('0);
        // Write to the unused index must not restart the image.
        drain();
        cfg_write(CFG_UNUSED, '1);
        send_pixel(32'h8000_0000);
        send_word(KIND_COEF, t_cidx'(3), 32'h7fff_ffff);
        send_pixel(32'h0000_0001);
        send_pixel('1);

        // Zero kernel, width and height all count as one: every pixel is a 1x1 image.
        drain();
        set_shape(0, 0, 0);
        send_pixel('1);
        send_pixel(32'h1234_5678);

        // Oversized width: the row runs on without an early wrap.
        drain();
        set_shape(1, 2047, 1);
        repeat (SAT_PIXELS) send_pixel(pick_pixel());

        // Oversized height: one-pixel rows keep counting down the image.
        drain();
        set_shape(1, 1, 8191);
        repeat (SAT_PIXELS) send_pixel(pick_pixel());

        while (random_words < RANDOM_WORDS) random_phase();

        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        for (int unsigned i = 0; i < END_WAIT && sb.pending() != 0; i++) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d window sums never came out", sb.pending());
            sb.mismatches++;
        end
        repeat (CLEAR_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver ready: runs of ready, short and occasional long stalls, and one long
    // hold-off once results are flowing so the block backs up into its input.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned pick;
        logic        long_hold_done;
        res_if.ready   = 1'b0;
        stall_left     = 0;
        run_left       = 0;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb.matched >= 50) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            if (stall_left == 0 && run_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) run_left = $urandom_range(1, 40);
                else if (pick < 92) stall_left = $urandom_range(1, 3);
                else stall_left = $urandom_range(10, 40);
            end
            if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                run_left--;
            end
        end
    end

    // A result word moves on a rising edge with valid and ready both high.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready) begin
            sb.check_result(res_if.conv_sum, res_if.out_row, res_if.out_col,
                            res_if.last_of_image);
        end
    end

    // Hard limit, far above the slowest legal run.
    initial begin : watchdog
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
